/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Every macro samples on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/dau_pkg.sv */
package dau_pkg;

    typedef enum logic [2:0] {
        OP_AAA = 3'd0,
        OP_AAS = 3'd1,
        OP_DAA = 3'd2,
        OP_DAS = 3'd3,
        OP_AAM = 3'd4,
        OP_AAD = 3'd5
    } t_op;

    // Pipeline shape: four register stages, two quotient bits of the AAM divide in each.
    localparam int PIPE_DEPTH = 4;
    localparam int DIV_STEPS  = 2;

    localparam logic [15:0] UNPACKED_ADJ = 16'h0106;
    localparam logic [3:0]  NIBBLE_MAX   = 4'd9;
    localparam logic [7:0]  PACKED_MAX   = 8'h99;
    localparam logic [7:0]  LOW_ADJ      = 8'h06;
    localparam logic [7:0]  HIGH_ADJ     = 8'h60;

    // Partial remainder and the shared dividend / quotient shift register.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] dq;
    } t_div;

    typedef struct packed {
        logic [15:0] ax;
        logic        af;
        logic        cf;
    } t_adj;

    typedef struct packed {
        t_op        op;
        logic [7:0] base;
        logic [7:0] aad;
        t_div       div;
        t_adj       res;
        logic       de;
    } t_item;

endpackage

/* hdl/dau_in_if.sv */
interface dau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] ax_in;
    logic        adjust_in;
    logic        carry_in;
    logic [7:0]  immediate_base;

    modport source (
        output valid, operation, ax_in, adjust_in, carry_in, immediate_base,
        input  ready
    );
    modport sink (
        input  valid, operation, ax_in, adjust_in, carry_in, immediate_base,
        output ready
    );
endinterface

/* hdl/dau_out_if.sv */
interface dau_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] ax_out;
    logic        adjust_out;
    logic        carry_out;
    logic        divide_error;

    modport source (
        output valid, ax_out, adjust_out, carry_out, divide_error,
        input  ready
    );
    modport sink (
        input  valid, ax_out, adjust_out, carry_out, divide_error,
        output ready
    );
endinterface

/* hdl/dau_bcd_adjust.sv */
module dau_bcd_adjust (
    input  dau_pkg::t_op  i_op,
    input  logic [15:0]   i_ax,
    input  logic          i_af,
    input  logic          i_cf,
    output dau_pkg::t_adj o_res
);
    import dau_pkg::*;

    logic [7:0]  al;
    logic        fix_lo;
    logic        fix_hi;
    logic [7:0]  lo_adj;
    logic [7:0]  hi_adj;
    logic [15:0] ax_sum;
    logic [15:0] ax_dif;
    logic [7:0]  al_add;
    logic [7:0]  al_sub;

    assign al     = i_ax[7:0];
    assign fix_lo = (al[3:0] > NIBBLE_MAX) || i_af;
    assign fix_hi = (al > PACKED_MAX) || i_cf;
    assign lo_adj = fix_lo ? LOW_ADJ : 8'h00;
    assign hi_adj = fix_hi ? HIGH_ADJ : 8'h00;
    assign ax_sum = i_ax + UNPACKED_ADJ;
    assign ax_dif = i_ax - UNPACKED_ADJ;
    assign al_add = al + lo_adj + hi_adj;
    assign al_sub = al - lo_adj - hi_adj;

    always_comb begin
        o_res = '{ax: i_ax, af: i_af, cf: i_cf};
        unique case (i_op)
            OP_AAA: begin
                o_res.ax = fix_lo ? {ax_sum[15:8], 4'h0, ax_sum[3:0]}
                                  : {i_ax[15:8], 4'h0, i_ax[3:0]};
                o_res.af = fix_lo;
                o_res.cf = fix_lo;
            end
            OP_AAS: begin
                o_res.ax = fix_lo ? {ax_dif[15:8], 4'h0, ax_dif[3:0]}
                                  : {i_ax[15:8], 4'h0, i_ax[3:0]};
                o_res.af = fix_lo;
                o_res.cf = fix_lo;
            end
            OP_DAA: begin
                o_res.ax = {i_ax[15:8], al_add};
                o_res.af = fix_lo;
                o_res.cf = fix_hi;
            end
            OP_DAS: begin
                // The low correction borrows out of AL when AL is below six.
                o_res.ax = {i_ax[15:8], al_sub};
                o_res.af = fix_lo;
                o_res.cf = fix_hi || (fix_lo && (i_cf || (al < LOW_ADJ)));
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/dau_div_stage.sv */
module dau_div_stage (
    input  dau_pkg::t_div i_div,
    input  logic [7:0]    i_base,
    output dau_pkg::t_div o_div
);
    import dau_pkg::*;

    logic [8:0] trial;
    t_div       d;

    // Restoring division, one quotient bit per step.
    always_comb begin
        d     = i_div;
        trial = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            trial = {d.rem, d.dq[7]};
            if (trial >= {1'b0, i_base}) begin
                d.rem = 8'(trial - {1'b0, i_base});
                d.dq  = {d.dq[6:0], 1'b1};
            end else begin
                d.rem = trial[7:0];
                d.dq  = {d.dq[6:0], 1'b0};
            end
        end
        o_div = d;
    end

endmodule

/* hdl/decimal_adjust_unit.sv */
// Decimal adjust unit: executes the x86 AAA, AAS, DAA, DAS, AAM and AAD
// instructions on a 16-bit AX value with the adjust and carry flags. Every
// transfer on the input channel yields exactly one transfer on the output
// channel, in order. The unit is a four-stage pipeline: a result is offered on
// the output from the last stage and leaves once the output is ready; a new
// item can be taken in every cycle unless a stalled output fills all stages.
// The depth is set by the AAM divide, which resolves two quotient bits per
// stage; the AAD multiply sits in the first stage and its add in the second.
// Empty stages fill while the output is stalled, so the input keeps taking
// items until all four stages hold one. AAM with a zero base raises
// divide_error and returns AX and the flags unchanged; AAM and AAD never
// change the flags, and the unused operation codes pass AX and the flags
// through. Sign, zero and parity flags are not produced.
`include "assert_macros.svh"

module decimal_adjust_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dau_in_if.sink    i_in,
    dau_out_if.source o_out
);
    import dau_pkg::*;

    // Per-stage valid bits and payload; the last stage is the output register.
    logic [PIPE_DEPTH-1:0] r_v;
    logic [PIPE_DEPTH-1:0] n_v;
    t_item                 r_item [PIPE_DEPTH];
    t_item                 n_item [PIPE_DEPTH];

    // A stage may load when it is empty or when its contents move on.
    logic [PIPE_DEPTH:0]   w_rdy;

    t_op                   w_op;
    t_adj                  w_bcd;
    logic [15:0]           w_prod;
    t_div                  w_div_in [PIPE_DEPTH];
    logic [7:0]            w_base   [PIPE_DEPTH];
    t_div                  w_div    [PIPE_DEPTH];

    assign w_rdy[PIPE_DEPTH] = o_out.ready;

    genvar k;
    generate
        for (k = 0; k < PIPE_DEPTH; k++) begin : g_stage
            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

            if (k == 0) begin : g_first
                // The divide starts with a zero remainder and AL as dividend.
                assign w_div_in[k] = '{rem: 8'h00, dq: i_in.ax_in[7:0]};
                assign w_base[k]   = i_in.immediate_base;
            end else begin : g_rest
                assign w_div_in[k] = r_item[k-1].div;
                assign w_base[k]   = r_item[k-1].base;
            end

            dau_div_stage u_div (
                .i_div  (w_div_in[k]),
                .i_base (w_base[k]),
                .o_div  (w_div[k])
            );
        end
    endgenerate

    assign i_in.ready = w_rdy[0];

    assign w_op   = t_op'(i_in.operation);
    assign w_prod = i_in.ax_in[15:8] * i_in.immediate_base;

    // The packed and unpacked BCD corrections finish in the first stage and
    // then ride along with the item.
    dau_bcd_adjust u_bcd (
        .i_op  (w_op),
        .i_ax  (i_in.ax_in),
        .i_af  (i_in.adjust_in),
        .i_cf  (i_in.carry_in),
        .o_res (w_bcd)
    );

    always_comb begin
        n_v = {r_v[PIPE_DEPTH-2:0], i_in.valid};

        n_item[0] = '{op: w_op, base: i_in.immediate_base, aad: w_prod[7:0],
                      div: w_div[0], res: w_bcd, de: 1'b0};
        for (int s = 1; s < PIPE_DEPTH; s++) begin
            n_item[s]     = r_item[s-1];
            n_item[s].div = w_div[s];
        end

        // AAD: AL + AH * base, with the product registered one stage earlier.
        n_item[1].aad = r_item[0].aad + r_item[0].res.ax[7:0];

        // The last stage completes the divide and selects the AAM or AAD result.
        unique case (r_item[PIPE_DEPTH-2].op)
            OP_AAM: begin
                if (r_item[PIPE_DEPTH-2].base == 8'h00) begin
                    n_item[PIPE_DEPTH-1].de = 1'b1;
                end else begin
                    n_item[PIPE_DEPTH-1].res.ax = {w_div[PIPE_DEPTH-1].dq,
                                                   w_div[PIPE_DEPTH-1].rem};
                end
            end
            OP_AAD: begin
                n_item[PIPE_DEPTH-1].res.ax = {8'h00, r_item[PIPE_DEPTH-2].aad};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < PIPE_DEPTH; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= n_v[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < PIPE_DEPTH; s++) begin
            if (w_rdy[s]) begin
                r_item[s] <= n_item[s];
            end
        end
    end

    assign o_out.valid        = r_v[PIPE_DEPTH-1];
    assign o_out.ax_out       = r_item[PIPE_DEPTH-1].res.ax;
    assign o_out.adjust_out   = r_item[PIPE_DEPTH-1].res.af;
    assign o_out.carry_out    = r_item[PIPE_DEPTH-1].res.cf;
    assign o_out.divide_error = r_item[PIPE_DEPTH-1].de;

    // A divide error only ever comes from AAM with a zero base.
    `ASSERT_ALWAYS(a_de_source, i_clk, i_rst_n,
        !(r_v[PIPE_DEPTH-1] && r_item[PIPE_DEPTH-1].de) ||
        (r_item[PIPE_DEPTH-1].op == OP_AAM && r_item[PIPE_DEPTH-1].base == 8'h00),
        "divide error without AAM by zero")

    // The AAM remainder must be below the base.
    `ASSERT_ALWAYS(a_aam_rem, i_clk, i_rst_n,
        !(r_v[PIPE_DEPTH-1] && r_item[PIPE_DEPTH-1].op == OP_AAM &&
          r_item[PIPE_DEPTH-1].base != 8'h00) ||
        (r_item[PIPE_DEPTH-1].res.ax[7:0] < r_item[PIPE_DEPTH-1].base),
        "AAM remainder not below base")

    // AAA and AAS set both flags from the same adjust decision.
    `ASSERT_ALWAYS(a_unpacked_flags, i_clk, i_rst_n,
        !(r_v[PIPE_DEPTH-1] && (r_item[PIPE_DEPTH-1].op == OP_AAA ||
                                r_item[PIPE_DEPTH-1].op == OP_AAS)) ||
        (r_item[PIPE_DEPTH-1].res.af == r_item[PIPE_DEPTH-1].res.cf),
        "AAA or AAS flags disagree")

    // A full stage that cannot move on keeps its item.
    `ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n,
        r_v[PIPE_DEPTH-2] && !w_rdy[PIPE_DEPTH-1],
        r_v[PIPE_DEPTH-2] && $stable(r_item[PIPE_DEPTH-2]),
        "stalled stage lost its item")

endmodule
